/* sv/gaussian_smooth_vector_stream_unit_defines.svh */
// Assertion helpers shared by the smoother's RTL.
// Both expect a clock named clk and an active-low reset named arst_n in scope.
`ifndef GAUSSIAN_SMOOTH_VECTOR_STREAM_UNIT_DEFINES_SVH
`define GAUSSIAN_SMOOTH_VECTOR_STREAM_UNIT_DEFINES_SVH

// Same-cycle implication
`define GSVS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define GSVS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/gsvs_pkg.sv */
`default_nettype none

package gsvs_pkg;

	// Fixed field widths and number formats
	localparam int SAMPLE_BITS    = 32;
	localparam int FRAC_BITS      = 16;
	localparam int COEF_W         = 16;
	localparam int WEIGHT_W       = 25;
	localparam int TAP_RADIUS_DEF = 12;

	// Request carried on the input channel
	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample_x;
		logic signed [SAMPLE_BITS-1:0] sample_y;
		logic signed [SAMPLE_BITS-1:0] sample_z;
		logic                          final_frame;
	} in_item_t;

	// Request carried on the output channel
	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] smooth_x;
		logic signed [SAMPLE_BITS-1:0] smooth_y;
		logic signed [SAMPLE_BITS-1:0] smooth_z;
		logic                          run_end;
	} out_item_t;

	// Status of one filter lane
	typedef struct packed {
		logic                          done;
		logic signed [SAMPLE_BITS-1:0] value;
	} lane_out_t;

	// Control from the sequencer to the output stage
	typedef struct packed {
		logic load;
		logic run_end;
	} merge_ctl_t;

	// Gaussian weight exp(-d*d/18) in unsigned Q1.24
	function automatic logic [WEIGHT_W-1:0] gauss_w(input int d);
		logic [WEIGHT_W-1:0] w;
		case (d)
			0:       w = 25'd16777216;
			1:       w = 25'd15870566;
			2:       w = 25'd13434144;
			3:       w = 25'd10175896;
			4:       w = 25'd6897320;
			5:       w = 25'd4183436;
			6:       w = 25'd2270549;
			7:       w = 25'd1102742;
			8:       w = 25'd479250;
			9:       w = 25'd186378;
			10:      w = 25'd64859;
			11:      w = 25'd20197;
			12:      w = 25'd5628;
			13:      w = 25'd1403;
			14:      w = 25'd313;
			15:      w = 25'd63;
			16:      w = 25'd11;
			17:      w = 25'd2;
			default: w = '0;
		endcase
		return w;
	endfunction

	// Kernel weight sum: centre plus both wings
	function automatic logic [31:0] gauss_total(input int radius);
		logic [31:0] sum;
		sum = 32'(gauss_w(0));
		for (int d = 1; d <= radius; d++) begin
			sum = sum + 32'(2 * gauss_w(d));
		end
		return sum;
	endfunction

endpackage

`default_nettype wire

/* sv/gsvs_lane.sv */
`default_nettype none

module gsvs_lane import gsvs_pkg::*; #(
	parameter int TAP_RADIUS = TAP_RADIUS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic [2*TAP_RADIUS:0][SAMPLE_BITS-1:0] taps,
	output lane_out_t                             res
);

	localparam int STEP_W = $clog2(TAP_RADIUS + 1);
	localparam int PAIR_W = SAMPLE_BITS + 1;
	localparam int PROD_W = PAIR_W + COEF_W + 1;
	localparam int ACC_W  = PROD_W + $clog2(TAP_RADIUS + 1);
	localparam int HI_W   = ACC_W - SAMPLE_BITS + 1;
	localparam logic [31:0] TOTAL = gauss_total(TAP_RADIUS);
	localparam logic signed [SAMPLE_BITS-1:0] SAT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] SAT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	logic [COEF_W-1:0]        coef_tab [TAP_RADIUS+1];
	logic signed [PAIR_W-1:0] pair_q   [TAP_RADIUS+1];
	logic                     busy_q;
	logic [STEP_W-1:0]        step_q;
	logic signed [PROD_W-1:0] prod_s1;
	logic                     pv_s1;
	logic                     pfirst_s1;
	logic                     plast_s1;
	logic signed [ACC_W-1:0]  acc_q;
	logic                     fin_s2;
	logic signed [ACC_W-1:0]  rnd;
	logic [HI_W-1:0]          hi;
	logic                     ovf;
	logic signed [SAMPLE_BITS-1:0] value_q;
	logic                     done_q;

	// Build the Q0.16 taps, step k pairs with distance TAP_RADIUS-k from the centre
	for (genvar k = 0; k <= TAP_RADIUS; k++) begin : g_coef
		localparam int DIST = TAP_RADIUS - k;
		localparam logic [47:0] CVAL =
			((48'(gauss_w(DIST)) << 16) + 48'(TOTAL / 2)) / 48'(TOTAL);
		assign coef_tab[k] = CVAL[COEF_W-1:0];
	end

	// Fold the symmetric window into pairs on start, then advance one pair a step
	always_ff @(posedge clk) begin
		if (start) begin
			for (int k = 0; k <= TAP_RADIUS; k++) begin
				if (k == TAP_RADIUS) begin
					pair_q[k] <= {taps[k][SAMPLE_BITS-1], taps[k]};
				end else begin
					pair_q[k] <= $signed({taps[k][SAMPLE_BITS-1], taps[k]})
						+ $signed({taps[2*TAP_RADIUS-k][SAMPLE_BITS-1],
						taps[2*TAP_RADIUS-k]});
				end
			end
		end else if (busy_q) begin
			for (int k = 0; k < TAP_RADIUS; k++) begin
				pair_q[k] <= pair_q[k+1];
			end
		end
	end

	// Step sequencing and pipeline flags; the step count parks on the last pair
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			step_q    <= '0;
			pv_s1     <= 1'b0;
			pfirst_s1 <= 1'b0;
			plast_s1  <= 1'b0;
			fin_s2    <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == STEP_W'(TAP_RADIUS)) begin
					busy_q <= 1'b0;
				end else begin
					step_q <= step_q + STEP_W'(1);
				end
			end
			pv_s1     <= busy_q;
			pfirst_s1 <= busy_q && (step_q == '0);
			plast_s1  <= busy_q && (step_q == STEP_W'(TAP_RADIUS));
			fin_s2    <= pv_s1 && plast_s1;
			done_q    <= fin_s2;
		end
	end

	// Multiply one pair by its tap, then accumulate
	always_ff @(posedge clk) begin
		prod_s1 <= pair_q[0] * $signed({1'b0, coef_tab[step_q]});
		if (pv_s1) begin
			acc_q <= (pfirst_s1 ? ACC_W'(0) : acc_q) + ACC_W'(prod_s1);
		end
		if (fin_s2) begin
			value_q <= ovf ? (rnd[ACC_W-1] ? SAT_MIN : SAT_MAX) : rnd[SAMPLE_BITS-1:0];
		end
	end

	// Round half up out of Q.16 and detect overflow of the sample range
	assign rnd = (acc_q + ACC_W'(1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
	assign hi  = rnd[ACC_W-1:SAMPLE_BITS-1];
	assign ovf = !(&hi) && (|hi);

	assign res.done  = done_q;
	assign res.value = value_q;

endmodule

`default_nettype wire

/* sv/gsvs_merge.sv */
`default_nettype none

module gsvs_merge import gsvs_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  merge_ctl_t                  ctl,
	input  logic [2:0][SAMPLE_BITS-1:0] vals,
	input  logic                        stall,
	output out_item_t                   item,
	output logic                        valid,
	output logic                        free
);

	out_item_t item_q;
	logic      valid_q;

	// Output register can take a new request when empty or being drained
	assign free = !valid_q || !stall;

	// Hold the valid flag until the downstream side takes the request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.load) begin
			valid_q <= 1'b1;
		end else if (!stall) begin
			valid_q <= 1'b0;
		end
	end

	// Pack the three lane results and tag the end of the run
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			item_q.smooth_x <= vals[0];
			item_q.smooth_y <= vals[1];
			item_q.smooth_z <= vals[2];
			item_q.run_end  <= ctl.run_end;
		end
	end

	assign item  = item_q;
	assign valid = valid_q;

endmodule

`default_nettype wire

/* sv/gaussian_smooth_vector_stream_unit.sv */
// Channel  | Direction | Handshake                     | Payload
// sample   | in        | sample_valid / sample_stall   | in_item_t  (x, y, z, final_frame)
// smooth   | out       | smooth_valid / smooth_stall   | out_item_t (x, y, z, run_end)
//
// A request that produces no result is taken with no stall; one that emits a
// smoothed frame stalls the input while the three component lanes run, each
// stepping one multiplier over TAP_RADIUS+1 tap pairs, and until the result is handed off.
// The last frame of a run adds one window shift per flushed result, plus
// TAP_RADIUS-p extra shifts when only p frames are pending.
// Reset clears the sequencer and flags only; the window is refilled by the first frame.
// A stalled output holds the finished result while the next request is taken.
`default_nettype none
`include "gaussian_smooth_vector_stream_unit_defines.svh"

module gaussian_smooth_vector_stream_unit import gsvs_pkg::*; #(
	parameter int TAP_RADIUS = TAP_RADIUS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      sample_valid,
	output logic      sample_stall,
	input  in_item_t  sample,
	output logic      smooth_valid,
	input  logic      smooth_stall,
	output out_item_t smooth
);

	localparam int DEPTH = 2 * TAP_RADIUS + 1;
	localparam int CNT_W = $clog2(TAP_RADIUS + 2);
	localparam logic [CNT_W-1:0] RAD = CNT_W'(TAP_RADIUS);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SHIFT = 3'd1;
	localparam logic [2:0] ST_START = 3'd2;
	localparam logic [2:0] ST_CALC  = 3'd3;
	localparam logic [2:0] ST_PUT   = 3'd4;

	logic [2:0]                             state_q;
	logic                                   started_q;
	logic [CNT_W-1:0]                       fs_q;
	logic [CNT_W-1:0]                       pend_q;
	logic [CNT_W-1:0]                       shift_q;
	logic                                   steady_q;
	logic [2:0][SAMPLE_BITS-1:0]            hold_q;
	logic [2:0][DEPTH-1:0][SAMPLE_BITS-1:0] win_q;

	logic                        accept;
	logic [2:0][SAMPLE_BITS-1:0] smp_in;
	logic [2:0][SAMPLE_BITS-1:0] shift_src;
	logic [CNT_W-1:0]            fs_next;
	logic                        emit_now;
	logic [CNT_W-1:0]            p_now;
	logic                        fill_en;
	logic                        shift_en;
	logic                        lane_start;
	lane_out_t [2:0]             lane_res;
	logic [2:0][SAMPLE_BITS-1:0] vals;
	merge_ctl_t                  merge_ctl;
	logic                        merge_free;

	assign sample_stall = (state_q != ST_IDLE);
	assign accept       = sample_valid && !sample_stall;

	assign smp_in[0] = sample.sample_x;
	assign smp_in[1] = sample.sample_y;
	assign smp_in[2] = sample.sample_z;

	// Pending count after this request, and whether the centre frame is due
	assign fs_next  = started_q ? fs_q + CNT_W'(1) : CNT_W'(1);
	assign emit_now = fs_next > RAD;
	assign p_now    = emit_now ? RAD : fs_next;

	// Window: fill on the first frame, shift on later frames and flush steps
	assign fill_en   = accept && !started_q;
	assign shift_en  = (accept && started_q) || (state_q == ST_SHIFT);
	assign shift_src = accept ? smp_in : hold_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			hold_q <= smp_in;
		end
		for (int c = 0; c < 3; c++) begin
			if (fill_en) begin
				for (int t = 0; t < DEPTH; t++) begin
					win_q[c][t] <= smp_in[c];
				end
			end else if (shift_en) begin
				win_q[c][0] <= shift_src[c];
				for (int t = 1; t < DEPTH; t++) begin
					win_q[c][t] <= win_q[c][t-1];
				end
			end
		end
	end

	// Sequencer: take a request, shift for the flush, run the lanes, hand off
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			started_q <= 1'b0;
			fs_q      <= '0;
			pend_q    <= '0;
			shift_q   <= '0;
			steady_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						steady_q <= emit_now;
						if (sample.final_frame) begin
							pend_q    <= p_now;
							shift_q   <= RAD - p_now + CNT_W'(1);
							started_q <= 1'b0;
							fs_q      <= '0;
						end else begin
							pend_q    <= '0;
							started_q <= 1'b1;
							fs_q      <= p_now;
						end
						if (emit_now) begin
							state_q <= ST_START;
						end else if (sample.final_frame) begin
							state_q <= ST_SHIFT;
						end
					end
				end
				ST_SHIFT: begin
					shift_q <= shift_q - CNT_W'(1);
					if (shift_q == CNT_W'(1)) begin
						state_q <= ST_START;
					end
				end
				ST_START: begin
					state_q <= ST_CALC;
				end
				ST_CALC: begin
					if (lane_res[0].done) begin
						state_q <= ST_PUT;
					end
				end
				ST_PUT: begin
					if (merge_free) begin
						if (steady_q) begin
							steady_q <= 1'b0;
							state_q  <= (pend_q != '0) ? ST_SHIFT : ST_IDLE;
						end else begin
							pend_q <= pend_q - CNT_W'(1);
							if (pend_q == CNT_W'(1)) begin
								state_q <= ST_IDLE;
							end else begin
								shift_q <= CNT_W'(1);
								state_q <= ST_SHIFT;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// One filter lane per component
	assign lane_start = (state_q == ST_START);

	for (genvar c = 0; c < 3; c++) begin : g_lane
		gsvs_lane #(
			.TAP_RADIUS(TAP_RADIUS)
		) u_lane (
			.clk   (clk),
			.arst_n(arst_n),
			.start (lane_start),
			.taps  (win_q[c]),
			.res   (lane_res[c])
		);
		assign vals[c] = lane_res[c].value;
	end

	// Output stage
	assign merge_ctl.load    = (state_q == ST_PUT) && merge_free;
	assign merge_ctl.run_end = !steady_q && (pend_q == CNT_W'(1));

	gsvs_merge u_merge (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (merge_ctl),
		.vals  (vals),
		.stall (smooth_stall),
		.item  (smooth),
		.valid (smooth_valid),
		.free  (merge_free)
	);

	// Lanes run in lockstep
	`GSVS_ASSERT_NOW(a_lane_lockstep, lane_res[0].done, lane_res[1].done && lane_res[2].done, "lanes finished out of step")
	// Fixed lane latency from start to result
	`GSVS_ASSERT_NOW(a_lane_latency, state_q == ST_START, ##(TAP_RADIUS + 4) lane_res[0].done, "lane result late or early")
	// A flush shift is never entered with nothing left to shift
	`GSVS_ASSERT_NOW(a_shift_count, state_q == ST_SHIFT, shift_q != '0, "flush shift count ran out")
	// The run's last result returns the block to idle
	`GSVS_ASSERT_NEXT(a_run_end_idle, merge_ctl.load && merge_ctl.run_end, state_q == ST_IDLE && !started_q, "run did not rearm after its last result")

endmodule

`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
	import gsvs_pkg::*;

	localparam int RADIUS    = TAP_RADIUS_DEF;
	localparam int SPAN      = 2 * RADIUS + 1;
	localparam int N_ITEMS   = 250;
	localparam int LIMIT     = 300000;
	localparam int LONG_HOLD = 400;
	localparam int TAIL      = 300;

	localparam logic [31:0] S_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] S_MIN = 32'h8000_0000;

	// Sample styles for one random sequence
	typedef enum int {
		STYLE_FULL,
		STYLE_SMALL,
		STYLE_EDGE,
		STYLE_MIXED
	} sample_style_e;

	// One request with an optional hand-written expectation
	typedef struct {
		in_item_t  req;
		bit        typed;
		out_item_t want;
	} stim_row_t;

	logic      clk;
	logic      arst_n;
	logic      sample_valid;
	logic      sample_stall;
	in_item_t  sample;
	logic      smooth_valid;
	logic      smooth_stall;
	out_item_t smooth;

	// Gaussian weights exp(-d*d/18) in Q1.24, centre first
	longint gauss_q24[RADIUS+1] = '{
		16777216, 15870566, 13434144, 10175896, 6897320, 4183436, 2270549,
		1102742, 479250, 186378, 64859, 20197, 5628
	};

	longint    tap_coef[SPAN];
	longint    win[SPAN][3];
	int        pending;
	bit        in_run;

	out_item_t smooth_expect_q[$];
	stim_row_t offered_q[$];
	stim_row_t directed_q[$];
	int        fail_count;
	int        sent;
	int        cycle_count;
	bit        long_hold_req;

	gaussian_smooth_vector_stream_unit DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.smooth_valid (smooth_valid),
		.smooth_stall (smooth_stall),
		.smooth       (smooth)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// Normalise the weights into Q0.16 taps
	function automatic void build_kernel();
		longint total;
		int     d;
		total = gauss_q24[0];
		for (int k = 1; k <= RADIUS; k++) begin
			total += 2 * gauss_q24[k];
		end
		for (int t = 0; t < SPAN; t++) begin
			d = (t < RADIUS) ? RADIUS - t : t - RADIUS;
			tap_coef[t] = (gauss_q24[d] * 65536 + total / 2) / total;
		end
	endfunction

	// Advance the window by one frame, newest at index 0
	function automatic void shift_window(input longint s[3]);
		for (int t = SPAN - 1; t > 0; t--) begin
			win[t] = win[t-1];
		end
		win[0] = s;
	endfunction

	// Filter the window, round half up and saturate each component
	function automatic out_item_t smooth_centre(input bit last);
		out_item_t r;
		longint    acc;
		longint    v[3];
		for (int c = 0; c < 3; c++) begin
			acc = 0;
			for (int t = 0; t < SPAN; t++) begin
				acc += win[t][c] * tap_coef[t];
			end
			acc = (acc + 32768) >>> 16;
			if (acc > 64'sd2147483647)
				acc = 64'sd2147483647;
			if (acc < -64'sd2147483648)
				acc = -64'sd2147483648;
			v[c] = acc;
		end
		r.smooth_x = 32'(v[0]);
		r.smooth_y = 32'(v[1]);
		r.smooth_z = 32'(v[2]);
		r.run_end  = last;
		return r;
	endfunction

	// Queue every smoothed frame that one accepted request releases
	function automatic void predict_request(input in_item_t req);
		longint s[3];
		int     p;
		int     shifts;
		s[0] = req.sample_x;
		s[1] = req.sample_y;
		s[2] = req.sample_z;
		if (!in_run) begin
			for (int t = 0; t < SPAN; t++) begin
				win[t] = s;
			end
			in_run  = 1'b1;
			pending = 1;
		end else begin
			shift_window(s);
			pending++;
		end
		if (pending > RADIUS) begin
			smooth_expect_q.push_back(smooth_centre(1'b0));
			pending = RADIUS;
		end
		if (req.final_frame) begin
			p      = pending;
			shifts = 0;
			for (int k = 0; k < p; k++) begin
				while (shifts < RADIUS - p + 1 + k) begin
					shift_window(s);
					shifts++;
				end
				smooth_expect_q.push_back(smooth_centre(k + 1 == p));
			end
			pending = 0;
			in_run  = 1'b0;
		end
	endfunction

	task automatic check_field(input string name, input logic signed [63:0] want_v,
			input logic signed [63:0] got_v);
		if (got_v !== want_v) begin
			$error("%s: expected %0d, got %0d", name, want_v, got_v);
			fail_count++;
		end
	endtask

	// Observe both channels: predict on each request taken, check each result taken
	always @(posedge clk) begin
		stim_row_t row;
		out_item_t want;
		int        n0;
		if (arst_n) begin
			if (sample_valid && !sample_stall) begin
				row = offered_q.pop_front();
				n0  = smooth_expect_q.size();
				predict_request(row.req);
				if (row.typed) begin
					while (smooth_expect_q.size() > n0)
						void'(smooth_expect_q.pop_back());
					smooth_expect_q.push_back(row.want);
				end
			end
			if (smooth_valid && !smooth_stall) begin
				if (smooth_expect_q.size() == 0) begin
					$error("smoothed frame with none pending: %p", smooth);
					fail_count++;
				end else begin
					want = smooth_expect_q.pop_front();
					check_field("smooth_x", 64'(want.smooth_x), 64'(smooth.smooth_x));
					check_field("smooth_y", 64'(want.smooth_y), 64'(smooth.smooth_y));
					check_field("smooth_z", 64'(want.smooth_z), 64'(smooth.smooth_z));
					check_field("run_end", 64'(want.run_end), 64'(smooth.run_end));
				end
			end
		end
	end

	// Mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [31:0] draw_sample(input sample_style_e style);
		sample_style_e pick;
		pick = style;
		if (style == STYLE_MIXED)
			pick = sample_style_e'($urandom_range(0, 2));
		case (pick)
			STYLE_SMALL: return $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;
			STYLE_EDGE:  return $urandom_range(0, 1) ? S_MAX - $urandom_range(0, 255)
			                                         : S_MIN + $urandom_range(0, 255);
			default:     return $urandom;
		endcase
	endfunction

	// Receiver: random stalls, calm stretches and one long hold
	initial begin
		int stall_left;
		int calm_left;
		int hold_left;
		stall_left   = 0;
		calm_left    = 0;
		hold_left    = 0;
		smooth_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				hold_left     = LONG_HOLD;
				long_hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				smooth_stall <= 1'b1;
				hold_left--;
			end else if (calm_left > 0) begin
				smooth_stall <= 1'b0;
				calm_left--;
			end else if (stall_left > 0) begin
				smooth_stall <= 1'b1;
				stall_left--;
			end else begin
				smooth_stall <= 1'b0;
				if ($urandom_range(0, 149) == 0)
					calm_left = $urandom_range(100, 200);
				else
					stall_left = pick_gap();
			end
		end
	end

	task automatic add_row(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z,
			input bit last, input bit typed, input out_item_t want);
		stim_row_t row;
		row.req   = '{sample_x: x, sample_y: y, sample_z: z, final_frame: last};
		row.typed = typed;
		row.want  = want;
		directed_q.push_back(row);
	endtask

	// Offer one request and hold it until taken
	task automatic send_request(input stim_row_t row, input bit burst);
		int gap;
		gap = burst ? 0 : pick_gap();
		repeat (gap) begin
			@(negedge clk);
			sample_valid <= 1'b0;
		end
		@(negedge clk);
		offered_q.push_back(row);
		sample_valid <= 1'b1;
		sample       <= row.req;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
		sent++;
	endtask

	task automatic wait_drained();
		while (smooth_expect_q.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		wait (cycle_count >= LIMIT);
		$display("[gaussian_smooth_vector_stream_unit] ERROR");
		$finish;
	end

	initial begin
		stim_row_t     row;
		sample_style_e style;
		int            len;
		int            r;
		bit            burst;
		bit            first;
		bit            paused;
		arst_n        = 1'b0;
		sample_valid  = 1'b0;
		sample        = '0;
		fail_count    = 0;
		sent          = 0;
		cycle_count   = 0;
		long_hold_req = 1'b0;
		pending       = 0;
		in_run        = 1'b0;
		build_kernel();

		// Single-frame runs: zero, minus one LSB, then the extremes
		add_row('0, '0, '0, 1'b1, 1'b1, '{smooth_x: '0, smooth_y: '0, smooth_z: '0,
			run_end: 1'b1});
		add_row('1, '1, '1, 1'b1, 1'b1, '{smooth_x: '1, smooth_y: '1, smooth_z: '1,
			run_end: 1'b1});
		add_row(S_MAX, S_MIN, S_MAX, 1'b1, 1'b0, '0);
		add_row(S_MIN, S_MAX, 32'd1, 1'b1, 1'b0, '0);
		// Two-frame run from one extreme to the other
		add_row(S_MAX, S_MAX, S_MAX, 1'b0, 1'b0, '0);
		add_row(S_MIN, S_MIN, S_MIN, 1'b1, 1'b0, '0);
		// Run long enough to reach steady output, then a full flush
		for (int k = 0; k < 14; k++)
			add_row(k[0] ? S_MAX : S_MIN, 32'h1_0000 * k, -k, k == 13, 1'b0, '0);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_q[i])
			send_request(directed_q[i], 1'b0);
		@(negedge clk);
		sample_valid <= 1'b0;
		wait_drained();

		// Random runs; the first is long and unbroken under a long output hold
		first  = 1'b1;
		paused = 1'b0;
		while (sent < N_ITEMS) begin
			r = $urandom_range(0, 9);
			if (first)
				len = 40;
			else if (r < 2)
				len = $urandom_range(1, 3);
			else if (r < 9)
				len = $urandom_range(4, 30);
			else
				len = $urandom_range(31, 60);
			// Trim the last run to the request budget
			if (len > N_ITEMS - sent)
				len = N_ITEMS - sent;
			style = sample_style_e'($urandom_range(0, 3));
			burst = first || ($urandom_range(0, 3) == 0);
			if (first)
				long_hold_req = 1'b1;
			for (int k = 0; k < len; k++) begin
				row.req.sample_x    = draw_sample(style);
				row.req.sample_y    = draw_sample(style);
				row.req.sample_z    = draw_sample(style);
				row.req.final_frame = (k == len - 1);
				row.typed           = 1'b0;
				row.want            = '0;
				send_request(row, burst);
			end
			first = 1'b0;
			// Hold the sender once until every frame is out
			if (!paused && sent >= N_ITEMS / 2) begin
				@(negedge clk);
				sample_valid <= 1'b0;
				wait_drained();
				paused = 1'b1;
			end
		end
		@(negedge clk);
		sample_valid <= 1'b0;

		wait_drained();
		repeat (TAIL) @(posedge clk);
		if (fail_count == 0)
			$display("[gaussian_smooth_vector_stream_unit] OK");
		else
			$display("[gaussian_smooth_vector_stream_unit] ERROR");
		$finish;
	end

endmodule
